// File: hw/rtl/crppi_pkg.sv
package crppi_pkg;

    localparam int HIST_BINS = 64;
    localparam int BIN_AW    = $clog2(HIST_BINS);
    localparam int CNT_W     = 32;
    localparam int PREFIX_W  = 63;
    localparam int POINT_W   = 64;

    localparam logic [CNT_W-1:0] SAT32 = {CNT_W{1'b1}};

    // bit-length unit: value split into chunks, one priority step per chunk
    localparam int BL_CW     = 8;
    localparam int BL_CHUNKS = POINT_W / BL_CW;
    localparam int BL_LW     = $clog2(BL_CW + 1);

    // result kinds
    localparam logic [2:0] RK_ROW     = 3'd0;
    localparam logic [2:0] RK_ENTRY   = 3'd1;
    localparam logic [2:0] RK_BIN     = 3'd2;
    localparam logic [2:0] RK_SUMMARY = 3'd3;
    localparam logic [2:0] RK_ERROR   = 3'd4;

    // configuration register indexes
    localparam logic [1:0] REG_START_BITS = 2'd0;
    localparam logic [1:0] REG_END_BITS   = 2'd1;
    localparam logic [1:0] REG_CKPT_BITS  = 2'd2;
    localparam logic [1:0] REG_HIST_MODE  = 2'd3;

    // bin store operations
    localparam logic [1:0] BIN_OP_NONE  = 2'd0;
    localparam logic [1:0] BIN_OP_INC   = 2'd1;
    localparam logic [1:0] BIN_OP_DRAIN = 2'd2;

    typedef struct packed {
        logic [1:0]        op;
        logic [BIN_AW-1:0] addr;
    } bin_req_t;

    typedef struct packed {
        logic [2:0]          kind;
        logic [POINT_W-1:0]  row;
        logic [3:0]          bytes;
        logic [PREFIX_W-1:0] prefix;
        logic [CNT_W-1:0]    count;
        logic [CNT_W-1:0]    empty;
        logic [5:0]          bin;
        logic [6:0]          cbits;
        logic                last;
    } out_item_t;

    function automatic logic [BL_LW-1:0] chunk_len(input logic [BL_CW-1:0] b);
        logic [BL_LW-1:0] n;
        n = '0;
        for (int i = 0; i < BL_CW; i++) begin
            if (b[i]) begin
                n = BL_LW'(i + 1);
            end
        end
        return n;
    endfunction

endpackage

// File: hw/rtl/crppi_bitlen.sv
module crppi_bitlen (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [crppi_pkg::POINT_W-1:0] value,
    output logic        done,
    output logic [6:0]  len
);
    import crppi_pkg::*;

    logic [BL_CHUNKS-1:0]            nz_reg;
    logic [BL_CHUNKS-1:0][BL_LW-1:0] clen_reg;
    logic                            s1_reg;
    logic                            s2_reg;
    logic [6:0]                      len_reg;
    logic [6:0]                      len_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_reg <= 1'b0;
            s2_reg <= 1'b0;
        end else begin
            s1_reg <= start;
            s2_reg <= s1_reg;
        end
    end

    // first stage: per-chunk length, second stage: pick the highest nonzero chunk
    always_ff @(posedge aclk) begin
        for (int i = 0; i < BL_CHUNKS; i++) begin
            nz_reg[i]   <= |value[i*BL_CW +: BL_CW];
            clen_reg[i] <= chunk_len(value[i*BL_CW +: BL_CW]);
        end
        len_reg <= len_next;
    end

    always_comb begin
        len_next = 7'd1;
        for (int i = 0; i < BL_CHUNKS; i++) begin
            if (nz_reg[i]) begin
                len_next = 7'(i * BL_CW) + 7'(clen_reg[i]);
            end
        end
    end

    assign done = s2_reg;
    assign len  = len_reg;

endmodule

// File: hw/rtl/crppi_bin_store.sv
module crppi_bin_store (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  crppi_pkg::bin_req_t         req,
    output logic [crppi_pkg::CNT_W-1:0] rd_data
);
    import crppi_pkg::*;

    logic [CNT_W-1:0]     mem [HIST_BINS];
    logic [HIST_BINS-1:0] valid_reg;
    logic [CNT_W-1:0]     rdata_reg;
    logic                 rvld_reg;
    logic                 wb_pend_reg;
    logic [BIN_AW-1:0]    wb_addr_reg;
    logic [CNT_W-1:0]     cur;
    logic [CNT_W-1:0]     wb_data;

    // a bin never written since reset or drain reads as zero
    assign cur     = rvld_reg ? rdata_reg : '0;
    assign wb_data = (cur == SAT32) ? cur : cur + CNT_W'(1);
    assign rd_data = cur;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg   <= '0;
            wb_pend_reg <= 1'b0;
        end else begin
            wb_pend_reg <= (req.op == BIN_OP_INC);
            if (req.op == BIN_OP_DRAIN) begin
                valid_reg[req.addr] <= 1'b0;
            end
            if (wb_pend_reg) begin
                valid_reg[wb_addr_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.op != BIN_OP_NONE) begin
            rdata_reg <= mem[req.addr];
            rvld_reg  <= valid_reg[req.addr];
        end
        if (req.op == BIN_OP_INC) begin
            wb_addr_reg <= req.addr;
        end
        if (wb_pend_reg) begin
            mem[wb_addr_reg] <= wb_data;
        end
    end

    // the controller leaves the cycle of a writeback free
    a_inc_interlock: assert property (@(posedge aclk) disable iff (!aresetn)
        req.op == BIN_OP_INC |=> req.op == BIN_OP_NONE)
        else $error("bin request issued during increment writeback");

    a_drain_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        req.op == BIN_OP_DRAIN |=> !valid_reg[$past(req.addr)])
        else $error("drained bin still marked valid");

    a_inc_sets_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        req.op == BIN_OP_INC |=> ##1 valid_reg[$past(req.addr, 2)])
        else $error("incremented bin not marked valid");

endmodule

// File: hw/rtl/chain_row_packer_prefix_indexer.sv
// Chain row packer and prefix index builder.
// Input stream s_*: one request per chain (tuser 0) or a finish request (tuser 1).
// Output stream m_*: result items, tuser gives the result kind, tlast marks the
// last result of a request. Configuration is written through cfg_we / cfg_index /
// cfg_data by the user, only while the block is idle; the block does not enforce it.
// Pack mode: a chain request passes the shift, compare and emit steps of the
// control sequencer and gives its packed row, then an index entry when the
// prefix moves on, or an error result when it falls, which halts the block so
// that every later request gives an error until reset. A finish emits the entry
// of an open run and waits on the two-stage bit-length unit before the summary.
// Histogram mode: a chain passes the bit-length unit, then a read-modify-write
// of the bin memory; a finish drains all 64 bins one by one through the single
// read port of the bin memory, clearing each bin as it goes.
// One request is in work at a time; s_tready is high only while the sequencer
// waits for a request. Results pass through an output register, so a request
// can be taken while the last result still waits; while m_tready is low the
// sequencer holds at its next result. Reset loads the default configuration,
// clears the run state and the halt, and marks all bins empty at once.
module chain_row_packer_prefix_indexer (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,   // start_point[63:0], end_point[127:64]
    input  logic [0:0]   s_tuser,   // kind[0]
    output logic         m_tvalid,
    input  logic         m_tready,
    // packed_row[63:0], row_bytes[67:64], group_prefix[130:68],
    // chain_count[162:131], empty_before[194:163], bin_number[200:195],
    // count_bits[207:201]
    output logic [207:0] m_tdata,
    output logic [2:0]   m_tuser,   // result_kind[2:0]
    output logic         m_tlast,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [5:0]   cfg_data
);
    import crppi_pkg::*;

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_CALC    = 4'd1;
    localparam logic [3:0] ST_DECIDE  = 4'd2;
    localparam logic [3:0] ST_ROW     = 4'd3;
    localparam logic [3:0] ST_ENTRY   = 4'd4;
    localparam logic [3:0] ST_ERROR   = 4'd5;
    localparam logic [3:0] ST_HALT    = 4'd6;
    localparam logic [3:0] ST_BLSTART = 4'd7;
    localparam logic [3:0] ST_BLWAIT  = 4'd8;
    localparam logic [3:0] ST_HINC    = 4'd9;
    localparam logic [3:0] ST_SUMMARY = 4'd10;
    localparam logic [3:0] ST_HDRAIN  = 4'd11;
    localparam logic [3:0] ST_HOUT    = 4'd12;

    localparam logic [BIN_AW-1:0] LAST_BIN = BIN_AW'(HIST_BINS - 1);

    // configuration
    logic [5:0] start_bits_reg;
    logic [5:0] end_bits_reg;
    logic [4:0] ckpt_bits_reg;
    logic       hist_mode_reg;

    // control and run state
    logic [3:0]          state_reg, state_next;
    logic                run_open_reg, run_open_next;
    logic [PREFIX_W-1:0] run_prefix_reg, run_prefix_next;
    logic [CNT_W-1:0]    run_count_reg, run_count_next;
    logic [PREFIX_W-1:0] first_prefix_reg, first_prefix_next;
    logic [PREFIX_W-1:0] last_entry_prefix_reg, last_entry_prefix_next;
    logic                entry_emitted_reg, entry_emitted_next;
    logic [CNT_W-1:0]    largest_count_reg, largest_count_next;
    logic                halted_reg, halted_next;
    logic                m_tvalid_reg, m_tvalid_next;

    // request payload and intermediate results
    logic                kind_reg, kind_next;
    logic [POINT_W-1:0]  sp_reg, sp_next;
    logic [POINT_W-1:0]  ep_reg, ep_next;
    logic [POINT_W-1:0]  row_reg, row_next;
    logic [3:0]          bytes_reg, bytes_next;
    logic [PREFIX_W-1:0] prefix_reg, prefix_next;
    logic                eq_reg, eq_next;
    logic                lt_reg, lt_next;
    logic [CNT_W-1:0]    empty_reg, empty_next;
    logic [BIN_AW-1:0]   bin_k_reg, bin_k_next;
    out_item_t           out_item_reg, out_item_next;

    // combinational helpers
    logic                out_free;
    logic                emit;
    out_item_t           item;
    logic [CNT_W-1:0]    end_mask;
    logic [POINT_W-1:0]  ep_shifted;
    logic [7:0]          total_bits;
    logic [4:0]          bytes_full;
    logic [PREFIX_W-1:0] gap_m1;
    logic [CNT_W-1:0]    gap_sat;

    logic                bl_start;
    logic [POINT_W-1:0]  bl_value;
    logic                bl_done;
    logic [6:0]          bl_len;
    bin_req_t            bin_req;
    logic [CNT_W-1:0]    bin_rdata;

    crppi_bitlen u_bitlen (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (bl_start),
        .value   (bl_value),
        .done    (bl_done),
        .len     (bl_len)
    );

    crppi_bin_store u_bin_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (bin_req),
        .rd_data (bin_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_bits_reg <= 6'd40;
            end_bits_reg   <= 6'd16;
            ckpt_bits_reg  <= 5'd0;
            hist_mode_reg  <= 1'b0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_START_BITS: start_bits_reg <= cfg_data;
                REG_END_BITS:   end_bits_reg   <= cfg_data;
                REG_CKPT_BITS:  ckpt_bits_reg  <= cfg_data[4:0];
                REG_HIST_MODE:  hist_mode_reg  <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // row packing
    assign end_mask   = (end_bits_reg >= 6'd32) ? SAT32 : ~(SAT32 << end_bits_reg[4:0]);
    assign ep_shifted = ep_reg >> end_bits_reg;
    assign total_bits = 8'(start_bits_reg) + 8'(end_bits_reg) + 8'(ckpt_bits_reg);
    assign bytes_full = 5'((total_bits + 8'd7) >> 3);

    // empty prefixes: run_prefix - last_entry_prefix - 1, modulo the prefix width
    assign gap_m1  = run_prefix_reg + ~last_entry_prefix_reg;
    assign gap_sat = (|gap_m1[PREFIX_W-1:CNT_W]) ? SAT32 : gap_m1[CNT_W-1:0];

    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        state_next             = state_reg;
        run_open_next          = run_open_reg;
        run_prefix_next        = run_prefix_reg;
        run_count_next         = run_count_reg;
        first_prefix_next      = first_prefix_reg;
        last_entry_prefix_next = last_entry_prefix_reg;
        entry_emitted_next     = entry_emitted_reg;
        largest_count_next     = largest_count_reg;
        halted_next            = halted_reg;
        kind_next              = kind_reg;
        sp_next                = sp_reg;
        ep_next                = ep_reg;
        row_next               = row_reg;
        bytes_next             = bytes_reg;
        prefix_next            = prefix_reg;
        eq_next                = eq_reg;
        lt_next                = lt_reg;
        empty_next             = empty_reg;
        bin_k_next             = bin_k_reg;
        emit                   = 1'b0;
        item                   = '0;
        bl_start               = 1'b0;
        bl_value               = kind_reg ? POINT_W'(largest_count_reg) : sp_reg;
        bin_req.op             = BIN_OP_NONE;
        bin_req.addr           = bin_k_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    kind_next = s_tuser[0];
                    sp_next   = s_tdata[63:0];
                    ep_next   = s_tdata[127:64];
                    if (halted_reg) begin
                        state_next = ST_HALT;
                    end else if (hist_mode_reg) begin
                        if (!s_tuser[0]) begin
                            state_next = ST_BLSTART;
                        end else begin
                            bin_k_next = '0;
                            state_next = ST_HDRAIN;
                        end
                    end else begin
                        state_next = s_tuser[0] ? ST_DECIDE : ST_CALC;
                    end
                end
            end
            ST_CALC: begin
                row_next    = sp_reg | (POINT_W'(ep_reg[CNT_W-1:0] & end_mask) << start_bits_reg);
                bytes_next  = (bytes_full > 5'd15) ? 4'd15 : bytes_full[3:0];
                prefix_next = ep_shifted[PREFIX_W-1:0];
                state_next  = ST_DECIDE;
            end
            ST_DECIDE: begin
                eq_next = (prefix_reg == run_prefix_reg);
                lt_next = (prefix_reg < run_prefix_reg);
                if (entry_emitted_reg && gap_m1 != '0 && gap_m1 != '1) begin
                    empty_next = gap_sat;
                end else begin
                    empty_next = '0;
                end
                if (!kind_reg) begin
                    state_next = ST_ROW;
                end else begin
                    state_next = run_open_reg ? ST_ENTRY : ST_BLSTART;
                end
            end
            ST_ROW: begin
                emit       = 1'b1;
                item.kind  = RK_ROW;
                item.row   = row_reg;
                item.bytes = bytes_reg;
                item.last  = !run_open_reg || eq_reg;
                if (out_free) begin
                    if (!run_open_reg) begin
                        run_open_next   = 1'b1;
                        run_prefix_next = prefix_reg;
                        run_count_next  = CNT_W'(1);
                        if (!entry_emitted_reg) begin
                            first_prefix_next = prefix_reg;
                        end
                        state_next = ST_IDLE;
                    end else if (eq_reg) begin
                        if (run_count_reg != SAT32) begin
                            run_count_next = run_count_reg + CNT_W'(1);
                        end
                        state_next = ST_IDLE;
                    end else if (lt_reg) begin
                        state_next = ST_ERROR;
                    end else begin
                        state_next = ST_ENTRY;
                    end
                end
            end
            ST_ENTRY: begin
                emit        = 1'b1;
                item.kind   = RK_ENTRY;
                item.prefix = run_prefix_reg;
                item.count  = run_count_reg;
                item.empty  = empty_reg;
                item.last   = !kind_reg;
                if (out_free) begin
                    if (run_count_reg > largest_count_reg) begin
                        largest_count_next = run_count_reg;
                    end
                    last_entry_prefix_next = run_prefix_reg;
                    entry_emitted_next     = 1'b1;
                    if (!kind_reg) begin
                        run_prefix_next = prefix_reg;
                        run_count_next  = CNT_W'(1);
                        state_next      = ST_IDLE;
                    end else begin
                        state_next = ST_BLSTART;
                    end
                end
            end
            ST_ERROR: begin
                emit        = 1'b1;
                item.kind   = RK_ERROR;
                item.prefix = prefix_reg;
                item.last   = 1'b1;
                if (out_free) begin
                    halted_next = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            ST_HALT: begin
                emit      = 1'b1;
                item.kind = RK_ERROR;
                item.last = 1'b1;
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            ST_BLSTART: begin
                bl_start   = 1'b1;
                state_next = ST_BLWAIT;
            end
            ST_BLWAIT: begin
                if (bl_done) begin
                    if (!kind_reg) begin
                        bin_req.op   = BIN_OP_INC;
                        bin_req.addr = BIN_AW'(bl_len - 7'd1);
                        state_next   = ST_HINC;
                    end else begin
                        state_next = ST_SUMMARY;
                    end
                end
            end
            ST_HINC: begin
                // bin writeback completes at the end of this cycle
                state_next = ST_IDLE;
            end
            ST_SUMMARY: begin
                emit        = 1'b1;
                item.kind   = RK_SUMMARY;
                item.prefix = first_prefix_reg;
                item.cbits  = bl_len;
                item.last   = 1'b1;
                if (out_free) begin
                    run_open_next          = 1'b0;
                    entry_emitted_next     = 1'b0;
                    run_prefix_next        = '0;
                    run_count_next         = '0;
                    first_prefix_next      = '0;
                    last_entry_prefix_next = '0;
                    largest_count_next     = '0;
                    state_next             = ST_IDLE;
                end
            end
            ST_HDRAIN: begin
                bin_req.op   = BIN_OP_DRAIN;
                bin_req.addr = bin_k_reg;
                state_next   = ST_HOUT;
            end
            ST_HOUT: begin
                emit       = 1'b1;
                item.kind  = RK_BIN;
                item.count = bin_rdata;
                item.bin   = 6'(bin_k_reg);
                item.last  = (bin_k_reg == LAST_BIN);
                if (out_free) begin
                    if (bin_k_reg == LAST_BIN) begin
                        state_next = ST_IDLE;
                    end else begin
                        bin_k_next = bin_k_reg + BIN_AW'(1);
                        state_next = ST_HDRAIN;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        out_item_next = out_item_reg;
        m_tvalid_next = m_tvalid_reg;
        if (emit && out_free) begin
            out_item_next = item;
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg             <= ST_IDLE;
            run_open_reg          <= 1'b0;
            run_prefix_reg        <= '0;
            run_count_reg         <= '0;
            first_prefix_reg      <= '0;
            last_entry_prefix_reg <= '0;
            entry_emitted_reg     <= 1'b0;
            largest_count_reg     <= '0;
            halted_reg            <= 1'b0;
            m_tvalid_reg          <= 1'b0;
        end else begin
            state_reg             <= state_next;
            run_open_reg          <= run_open_next;
            run_prefix_reg        <= run_prefix_next;
            run_count_reg         <= run_count_next;
            first_prefix_reg      <= first_prefix_next;
            last_entry_prefix_reg <= last_entry_prefix_next;
            entry_emitted_reg     <= entry_emitted_next;
            largest_count_reg     <= largest_count_next;
            halted_reg            <= halted_next;
            m_tvalid_reg          <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg     <= kind_next;
        sp_reg       <= sp_next;
        ep_reg       <= ep_next;
        row_reg      <= row_next;
        bytes_reg    <= bytes_next;
        prefix_reg   <= prefix_next;
        eq_reg       <= eq_next;
        lt_reg       <= lt_next;
        empty_reg    <= empty_next;
        bin_k_reg    <= bin_k_next;
        out_item_reg <= out_item_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = out_item_reg.kind;
    assign m_tlast  = out_item_reg.last;
    assign m_tdata  = {out_item_reg.cbits, out_item_reg.bin, out_item_reg.empty,
                       out_item_reg.count, out_item_reg.prefix, out_item_reg.bytes,
                       out_item_reg.row};

    a_halt_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        halted_reg |=> halted_reg)
        else $error("halt cleared without reset");

    a_entry_needs_run: assert property (@(posedge aclk) disable iff (!aresetn)
        entry_emitted_reg |-> run_open_reg)
        else $error("entry history kept with no open run");

    a_open_run_count: assert property (@(posedge aclk) disable iff (!aresetn)
        run_open_reg |-> run_count_reg != '0)
        else $error("open run with zero chain count");

    a_halted_request: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && halted_reg |=> state_reg == ST_HALT)
        else $error("request while halted not routed to error result");

endmodule

// File: dv/chain_row_packer_prefix_indexer_tb.sv
module chain_row_packer_prefix_indexer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import crppi_pkg::*;

    localparam logic        KIND_CHAIN    = 1'b0;
    localparam logic        KIND_FINISH   = 1'b1;
    localparam int          SETTLE_CYCLES = 24;
    localparam logic [62:0] ALL63         = {63{1'b1}};

    logic         aclk = 1'b0;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [127:0] s_tdata;
    logic [0:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [207:0] m_tdata;
    logic [2:0]   m_tuser;
    logic         m_tlast;
    logic         cfg_we;
    logic [1:0]   cfg_index;
    logic [5:0]   cfg_data;

    bit src_fast;
    bit snk_fast;
    int items_sent;

    function automatic logic [6:0] bits_needed(input logic [63:0] v);
        logic [6:0] n;
        n = 7'd1;
        for (int i = 1; i < 64; i++) begin
            if (v[i]) begin
                n = 7'(i + 1);
            end
        end
        return n;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    class packer_index_tracker;
        logic [5:0]  start_bits;
        logic [5:0]  end_bits;
        logic [4:0]  ckpt_bits;
        logic        hist_mode;
        logic        run_open;
        logic        entry_emitted;
        logic        halted;
        logic [62:0] run_prefix;
        logic [62:0] first_prefix;
        logic [62:0] last_entry_prefix;
        logic [31:0] run_count;
        logic [31:0] largest_count;
        logic [31:0] bin_counts [HIST_BINS];
        out_item_t   due_results [$];
        int          mismatches;

        function new();
            start_bits = 6'd40;
            end_bits   = 6'd16;
            ckpt_bits  = 5'd0;
            hist_mode  = 1'b0;
            halted     = 1'b0;
            mismatches = 0;
            clear_run();
            foreach (bin_counts[i]) bin_counts[i] = '0;
        endfunction

        function void clear_run();
            run_open          = 1'b0;
            entry_emitted     = 1'b0;
            run_prefix        = '0;
            run_count         = '0;
            first_prefix      = '0;
            last_entry_prefix = '0;
            largest_count     = '0;
        endfunction

        function void set_reg(input logic [1:0] idx, input logic [5:0] val);
            case (idx)
                REG_START_BITS: start_bits = val;
                REG_END_BITS:   end_bits   = val;
                REG_CKPT_BITS:  ckpt_bits  = val[4:0];
                REG_HIST_MODE:  hist_mode  = val[0];
                default: ;
            endcase
        endfunction

        function void add_result(input logic [2:0] kind, input logic [63:0] row,
                                 input logic [3:0] nbytes, input logic [62:0] prefix,
                                 input logic [31:0] count, input logic [31:0] empty,
                                 input logic [5:0] bin, input logic [6:0] cbits);
            out_item_t r;
            r.kind   = kind;
            r.row    = row;
            r.bytes  = nbytes;
            r.prefix = prefix;
            r.count  = count;
            r.empty  = empty;
            r.bin    = bin;
            r.cbits  = cbits;
            r.last   = 1'b0;
            due_results.insert(due_results.size(), r);
        endfunction

        // closes the current prefix run into an index entry
        function void flush_run();
            logic [62:0] d;
            logic [31:0] gap;
            gap = '0;
            if (entry_emitted) begin
                d = run_prefix - last_entry_prefix;
                if (d > 63'd1) begin
                    gap = (d - 63'd1 > 63'(SAT32)) ? SAT32 : 32'(d - 63'd1);
                end
            end
            add_result(RK_ENTRY, '0, '0, run_prefix, run_count, gap, '0, '0);
            if (run_count > largest_count) begin
                largest_count = run_count;
            end
            last_entry_prefix = run_prefix;
            entry_emitted     = 1'b1;
        endfunction

        function void note_request(input logic fin, input logic [63:0] sp,
                                   input logic [63:0] ep);
            int          n0;
            int          b;
            int          total;
            logic [63:0] mask;
            logic [62:0] pfx;
            logic [3:0]  nbytes;
            out_item_t   tail;
            n0 = due_results.size();
            if (halted) begin
                add_result(RK_ERROR, '0, '0, '0, '0, '0, '0, '0);
            end else if (hist_mode) begin
                if (!fin) begin
                    b = int'(bits_needed(sp)) - 1;
                    if (bin_counts[b] != SAT32) begin
                        bin_counts[b] = bin_counts[b] + 32'd1;
                    end
                end else begin
                    for (int k = 0; k < HIST_BINS; k++) begin
                        add_result(RK_BIN, '0, '0, '0, bin_counts[k], '0, 6'(k), '0);
                        bin_counts[k] = '0;
                    end
                end
            end else if (!fin) begin
                if (end_bits == 6'd0) begin
                    mask = '0;
                end else if (end_bits >= 6'd32) begin
                    mask = 64'hffff_ffff;
                end else begin
                    mask = (64'd1 << end_bits) - 64'd1;
                end
                total  = int'(start_bits) + int'(end_bits) + int'(ckpt_bits);
                nbytes = ((total + 7) / 8 > 15) ? 4'd15 : 4'((total + 7) / 8);
                pfx    = 63'(ep >> end_bits);
                add_result(RK_ROW, sp | ((ep & mask) << start_bits), nbytes,
                           '0, '0, '0, '0, '0);
                if (!run_open) begin
                    run_open   = 1'b1;
                    run_prefix = pfx;
                    run_count  = 32'd1;
                    if (!entry_emitted) begin
                        first_prefix = pfx;
                    end
                end else if (pfx == run_prefix) begin
                    if (run_count != SAT32) begin
                        run_count = run_count + 32'd1;
                    end
                end else if (pfx < run_prefix) begin
                    // prefix went backwards: stream is dead until reset
                    add_result(RK_ERROR, '0, '0, pfx, '0, '0, '0, '0);
                    halted = 1'b1;
                end else begin
                    flush_run();
                    run_prefix = pfx;
                    run_count  = 32'd1;
                end
            end else begin
                if (run_open) begin
                    flush_run();
                end
                add_result(RK_SUMMARY, '0, '0, first_prefix, '0, '0, '0,
                           bits_needed({32'd0, largest_count}));
                clear_run();
            end
            if (due_results.size() > n0) begin
                tail      = due_results[due_results.size() - 1];
                tail.last = 1'b1;
                due_results[due_results.size() - 1] = tail;
            end
        endfunction

        function void compare_field(input string name, input logic [63:0] want,
                                    input logic [63:0] got);
            if (got !== want) begin
                $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
                mismatches++;
            end
        endfunction

        function void check_result(input logic [2:0] kind, input logic [207:0] data,
                                   input logic last);
            out_item_t want;
            if (due_results.size() == 0) begin
                $error("result_kind: expected nothing, got %0d", kind);
                mismatches++;
                return;
            end
            want = due_results.pop_front();
            compare_field("result_kind",  64'(want.kind),   64'(kind));
            compare_field("packed_row",   want.row,         data[63:0]);
            compare_field("row_bytes",    64'(want.bytes),  64'(data[67:64]));
            compare_field("group_prefix", 64'(want.prefix), 64'(data[130:68]));
            compare_field("chain_count",  64'(want.count),  64'(data[162:131]));
            compare_field("empty_before", 64'(want.empty),  64'(data[194:163]));
            compare_field("bin_number",   64'(want.bin),    64'(data[200:195]));
            compare_field("count_bits",   64'(want.cbits),  64'(data[207:201]));
            compare_field("last",         64'(want.last),   64'(last));
        endfunction
    endclass

    packer_index_tracker tracker;

    chain_row_packer_prefix_indexer dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 aclk = ~aclk;

    task automatic send_request(input logic fin, input logic [63:0] sp,
                                input logic [63:0] ep);
        int gap;
        gap = src_fast ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= fin;
        s_tdata  <= {ep, sp};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        tracker.note_request(fin, sp, ep);
        items_sent++;
    endtask

    task automatic send_chain(input logic [63:0] sp, input logic [63:0] ep);
        send_request(KIND_CHAIN, sp, ep);
    endtask

    task automatic send_finish();
        send_request(KIND_FINISH, rand64(), rand64());
    endtask

    // hold off requests until every result is back, then let the sequencer settle
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (tracker.due_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [5:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        tracker.set_reg(idx, val);
    endtask

    task automatic configure(input logic [5:0] sb, input logic [5:0] eb,
                             input logic [5:0] cb, input logic hm);
        write_reg(REG_START_BITS, sb);
        write_reg(REG_END_BITS, eb);
        write_reg(REG_CKPT_BITS, cb);
        write_reg(REG_HIST_MODE, {5'd0, hm});
        cfg_we <= 1'b0;
    endtask

    task automatic random_config();
        logic [5:0] sb;
        logic [5:0] eb;
        logic [5:0] cb;
        case ($urandom_range(0, 3))
            0:       sb = 6'd1;
            1:       sb = 6'd63;
            default: sb = 6'($urandom_range(1, 63));
        endcase
        case ($urandom_range(0, 7))
            0:       eb = 6'd1;
            1:       eb = 6'd32;
            2:       eb = 6'($urandom_range(0, 63));
            default: eb = 6'($urandom_range(1, 32));
        endcase
        case ($urandom_range(0, 3))
            0:       cb = 6'd0;
            1:       cb = 6'd16;
            2:       cb = 6'd31;
            default: cb = 6'($urandom_range(0, 31));
        endcase
        configure(sb, eb, cb, $urandom_range(0, 2) == 0);
    endtask

    // chains with nondecreasing prefixes and random content, closed by a finish
    task automatic pack_stream();
        int          len;
        logic [5:0]  e;
        logic [63:0] maxp;
        logic [63:0] pfx;
        logic [63:0] step;
        logic [63:0] low;
        logic [63:0] ep;
        e    = tracker.end_bits;
        maxp = (e == 6'd0) ? {1'b0, ALL63} : ({64{1'b1}} >> e);
        pfx  = $urandom_range(0, 1) ? (rand64() & maxp) : (64'($urandom_range(0, 50)) & maxp);
        len  = $urandom_range(0, 12);
        for (int i = 0; i < len; i++) begin
            case ($urandom_range(0, 9)) inside
                [0:4]:   step = '0;
                [5:6]:   step = 64'd1;
                [7:8]:   step = 64'($urandom_range(2, 1000));
                default: step = rand64() >> $urandom_range(0, 32);
            endcase
            if (step > maxp - pfx) begin
                step = '0;
            end
            pfx = pfx + step;
            low = rand64();
            if (e == 6'd0) begin
                ep = {low[63], pfx[62:0]};
            end else begin
                ep = (pfx << e) | (low & ~({64{1'b1}} << e));
            end
            send_chain(rand64(), ep);
        end
        send_finish();
    endtask

    task automatic hist_stream();
        int len;
        len = $urandom_range(0, 15);
        for (int i = 0; i < len; i++) begin
            send_chain(rand64() >> $urandom_range(0, 64), rand64());
        end
        send_finish();
    endtask

    // result side: random stalls, every accepted result checked in order
    initial begin
        int stall;
        m_tready <= 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            stall = snk_fast ? 0 : $urandom_range(0, 15);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
            tracker.check_result(m_tuser, m_tdata, m_tlast);
        end
    end

    initial begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        tracker    = new();
        items_sent = 0;
        src_fast   = 1'b0;
        snk_fast   = 1'b0;
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= '0;
        cfg_we    <= 1'b0;
        cfg_index <= REG_START_BITS;
        cfg_data  <= '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // reset configuration: summary with no run, then gaps small and huge
        send_finish();
        send_chain(64'd0, 64'd0);
        send_chain({64{1'b1}}, 64'h0000_0000_0000_ffff);
        send_chain(rand64(), 64'h0000_0000_0003_1234);
        send_chain(rand64(), 64'h0000_0000_0004_0000);
        send_chain(rand64(), {64{1'b1}});
        send_finish();
        wait_drained();

        // widest row: byte count saturates, end bits beyond 32 clipped
        configure(6'd63, 6'd63, 6'd31, 1'b0);
        send_chain({64{1'b1}}, 64'd1);
        send_chain(64'd0, {64{1'b1}});
        send_finish();
        wait_drained();

        // no end bits stored, prefix drops bit 63; run left open across the mode switch
        configure(6'd1, 6'd0, 6'd0, 1'b0);
        send_chain(rand64(), 64'd5);
        send_chain(rand64(), 64'h8000_0000_0000_0005);
        wait_drained();
        configure(6'd1, 6'd0, 6'd0, 1'b1);
        send_chain(64'd0, rand64());
        send_chain(64'd1, rand64());
        send_chain({64{1'b1}}, rand64());
        send_chain(64'h8000_0000_0000_0000, rand64());
        send_chain(64'd2, rand64());
        send_finish();
        send_chain(64'd3, rand64());
        wait_drained();
        configure(6'd1, 6'd0, 6'd0, 1'b0);
        send_chain(rand64(), 64'd7);
        send_finish();
        wait_drained();

        while (items_sent < 85) begin
            random_config();
            src_fast = $urandom_range(0, 3) == 0;
            snk_fast = $urandom_range(0, 3) == 0;
            if (tracker.hist_mode) begin
                hist_stream();
            end else begin
                pack_stream();
            end
            wait_drained();
        end

        // falling prefix, then everything after the halt gives an error
        src_fast = 1'b0;
        snk_fast = 1'b0;
        configure(6'd40, 6'd16, 6'd0, 1'b0);
        send_chain(rand64(), 64'h0000_0000_000a_0000);
        send_chain(rand64(), 64'h0000_0000_0009_ffff);
        send_chain(rand64(), 64'h0000_0000_000b_0000);
        send_finish();
        wait_drained();
        configure(6'd40, 6'd16, 6'd0, 1'b1);
        send_chain(rand64(), rand64());
        send_finish();
        wait_drained();
        repeat (64) @(posedge aclk);

        if (tracker.mismatches == 0 && tracker.due_results.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
